// ===== sv/imu_fp_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU frame parser package
// Shared constants, token and result types for the serial frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_fp_pkg;

  localparam logic [7:0] HdrByte = 8'h55;
  localparam logic [7:0] TypeAcc = 8'h51;
  localparam logic [7:0] TypeAnv = 8'h52;
  localparam logic [7:0] TypeAng = 8'h53;

  localparam int PayloadBytesDef = 8;
  localparam int QueueDepthDef   = 4;
  localparam int IdxW            = 3;
  localparam int AxisBytes       = 6;

  typedef enum logic {
    TokData,
    TokCheck
  } tok_op_t;

  typedef struct packed {
    tok_op_t          op;
    logic [1:0]       kind;
    logic [IdxW-1:0]  idx;
    logic [7:0]       data;
    logic             good;
  } tok_t;

  typedef struct packed {
    logic [1:0]         frame_kind;
    logic               checksum_good;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [7:0]         got_checksum;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/imu_fp_fifo.sv =====
// ----------------------------------------------------------------------------
// IMU frame parser queue
// Small first-in first-out queue in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/imu_fp_front.sv =====
// ----------------------------------------------------------------------------
// IMU frame parser front end
// Hunts for the header, checks the type, sums the frame and emits tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fp_front #(
  parameter int PAYLOAD_BYTES = imu_fp_pkg::PayloadBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  byte_data,
  output logic             tok_push,
  output imu_fp_pkg::tok_t tok
);

  typedef enum logic [1:0] {
    StHunt,
    StType,
    StPayload,
    StCheck
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic [7:0]                  sum_r, sum_nxt;
  logic [imu_fp_pkg::IdxW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    tok_push  = 1'b0;
    tok.op    = imu_fp_pkg::TokData;
    tok.kind  = kind_r;
    tok.idx   = idx_r;
    tok.data  = byte_data;
    tok.good  = (byte_data == sum_r);
    if (byte_valid) begin
      case (state_r)
        StHunt: begin
          if (byte_data == imu_fp_pkg::HdrByte) begin
            state_nxt = StType;
          end
        end
        StType: begin
          if (byte_data inside {imu_fp_pkg::TypeAcc, imu_fp_pkg::TypeAnv,
                                imu_fp_pkg::TypeAng}) begin
            kind_nxt  = byte_data[1:0] - 2'd1;
            sum_nxt   = imu_fp_pkg::HdrByte + byte_data;
            idx_nxt   = '0;
            state_nxt = StPayload;
          end else begin
            state_nxt = StHunt;
          end
        end
        StPayload: begin
          tok_push = 1'b1;
          sum_nxt  = sum_r + byte_data;
          idx_nxt  = idx_r + imu_fp_pkg::IdxW'(1);
          if (idx_r == imu_fp_pkg::IdxW'(PAYLOAD_BYTES - 1)) begin
            state_nxt = StCheck;
          end
        end
        StCheck: begin
          tok_push  = 1'b1;
          tok.op    = imu_fp_pkg::TokCheck;
          state_nxt = StHunt;
        end
        default: begin
          state_nxt = StHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StHunt;
      kind_r  <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/imu_fp_back.sv =====
// ----------------------------------------------------------------------------
// IMU frame parser back end
// Stores payload bytes from the token queue and assembles one result a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fp_back (
  input  wire logic              clk,
  input  wire imu_fp_pkg::tok_t  tok,
  input  wire logic              tok_empty,
  output logic                   tok_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output imu_fp_pkg::res_t       res
);

  logic [7:0] bytes_r [imu_fp_pkg::AxisBytes];

  assign tok_pop  = !tok_empty && !res_full;
  assign res_push = tok_pop && (tok.op == imu_fp_pkg::TokCheck);

  assign res.frame_kind    = tok.kind;
  assign res.checksum_good = tok.good;
  assign res.axis_x        = {bytes_r[1], bytes_r[0]};
  assign res.axis_y        = {bytes_r[3], bytes_r[2]};
  assign res.axis_z        = {bytes_r[5], bytes_r[4]};
  assign res.got_checksum  = tok.data;

  always_ff @(posedge clk) begin
    for (int i = 0; i < imu_fp_pkg::AxisBytes; i++) begin
      if (tok_pop && (tok.op == imu_fp_pkg::TokData) &&
          (tok.idx == imu_fp_pkg::IdxW'(i))) begin
        bytes_r[i] <= tok.data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/imu_uart_frame_parser.sv =====
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Parses 11-byte inertial sensor frames and returns kind, checksum status
// and three signed axis counts per frame.
// ----------------------------------------------------------------------------
// Usage: received bytes enter through a queue-style port (in_push, in_full,
// in_rx_byte). A byte is taken at every edge where in_push is high and
// in_full is low, so one byte per cycle is sustained.
// Results leave through a queue-style port: while out_empty is low the oldest
// result is on the out_ ports and out_pop takes it.
// Every frame that reaches its checksum byte yields one result, with
// out_checksum_good low when the byte sum does not match.
// The front end classifies each byte in the cycle it is taken and writes a
// token for each payload and checksum byte to a four-entry queue; while the
// result queue is not full, the back end drains that queue one token per
// cycle into a four-entry result queue.
// When out_pop stays low, the result queue fills, the back end stops, the
// token queue fills and in_full rises; no byte or result is lost.
// A synchronous reset returns the parser to header hunting and empties both
// queues.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_uart_frame_parser #(
  parameter int PAYLOAD_BYTES = imu_fp_pkg::PayloadBytesDef,
  parameter int QUEUE_DEPTH   = imu_fp_pkg::QueueDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_frame_kind,
  output logic             out_checksum_good,
  output logic signed [15:0] out_axis_x,
  output logic signed [15:0] out_axis_y,
  output logic signed [15:0] out_axis_z,
  output logic [7:0]       out_got_checksum
);

  localparam int TokW = $bits(imu_fp_pkg::tok_t);
  localparam int ResW = $bits(imu_fp_pkg::res_t);

  logic             byte_valid;
  logic             tok_push, tok_pop, tok_empty;
  imu_fp_pkg::tok_t tok_in, tok_out;
  logic [TokW-1:0]  tok_rdata;
  logic             res_push, res_full;
  imu_fp_pkg::res_t res_in, res_out;
  logic [ResW-1:0]  res_rdata;

  assign byte_valid = in_push && !in_full;

  imu_fp_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .byte_data (in_rx_byte),
    .tok_push  (tok_push),
    .tok       (tok_in)
  );

  imu_fp_fifo #(
    .WIDTH(TokW),
    .DEPTH(QUEUE_DEPTH)
  ) u_tok_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (tok_push),
    .wdata(tok_in),
    .full (in_full),
    .pop  (tok_pop),
    .rdata(tok_rdata),
    .empty(tok_empty)
  );

  assign tok_out = imu_fp_pkg::tok_t'(tok_rdata);

  imu_fp_back u_back (
    .clk      (clk),
    .tok      (tok_out),
    .tok_empty(tok_empty),
    .tok_pop  (tok_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  imu_fp_fifo #(
    .WIDTH(ResW),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rdata),
    .empty(out_empty)
  );

  assign res_out           = imu_fp_pkg::res_t'(res_rdata);
  assign out_frame_kind    = res_out.frame_kind;
  assign out_checksum_good = res_out.checksum_good;
  assign out_axis_x        = res_out.axis_x;
  assign out_axis_y        = res_out.axis_y;
  assign out_axis_z        = res_out.axis_z;
  assign out_got_checksum  = res_out.got_checksum;

endmodule

`default_nettype wire

// ===== sv/imu_fp_checker.sv =====
// ----------------------------------------------------------------------------
// IMU frame parser checker
// Port-level assertions for the frame parser, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [1:0]  out_frame_kind,
  input wire logic [15:0] out_axis_x,
  input wire logic [7:0]  out_got_checksum
);

  // Reset empties both queues.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A waiting result that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_frame_kind) && $stable(out_axis_x) &&
       $stable(out_got_checksum)))
    else $error("stalled result changed");

  // Only the three known frame kinds are ever reported.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_frame_kind != 2'd3))
    else $error("invalid frame kind");

  // The input side cannot fill without a backlog of results.
  a_full_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> !out_empty)
    else $error("input full with no results waiting");

endmodule

bind imu_uart_frame_parser imu_fp_checker u_imu_fp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_frame_kind  (out_frame_kind),
  .out_axis_x      (out_axis_x),
  .out_got_checksum(out_got_checksum)
);

`default_nettype wire
